FILE: src/smv_pkg.sv
// Shared types and constants for the stream mean/variance block.
// Used by smv_dp, smv_ctrl, stream_mean_variance and the testbench; depends on nothing.

package smv_pkg;

    // Width of one sample, unsigned Q0.16
    localparam int SAMPLE_BITS = 16;
    // Width of the mean result, Q0.16
    localparam int MEAN_W      = 16;
    // Width of the variance result, Q0.32 with a maximum of 0.25
    localparam int SPREAD_W    = 31;

    // Result status codes
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_SINGLE = 1'b1;

    // Divider operand select
    localparam logic DIV_SEL_VAR  = 1'b0;
    localparam logic DIV_SEL_MEAN = 1'b1;

    typedef enum logic [3:0] {
        S_ACCUM,
        S_MUL,
        S_COMB,
        S_SUB,
        S_DIV_VAR,
        S_WAIT_VAR,
        S_DIV_MEAN,
        S_WAIT_MEAN,
        S_DONE,
        S_ERR
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic acc_en;
        logic clear;
        logic mul_en;
        logic comb_en;
        logic sub_en;
        logic div_start;
        logic div_sel;
        logic var_cap;
        logic load_ok;
        logic load_err;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic hit_max;
        logic single;
        logic div_busy;
    } status_t;

endpackage

FILE: src/smv_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; instantiated by smv_dp.

module smv_div #(
    parameter int DW = 53,
    parameter int VW = 22
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] dvs_reg, dvs_next;
    logic [VW:0]   shifted;
    logic [VW:0]   diff;
    logic          fits;

    // Trial subtract of the divisor from the shifted remainder
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DW-1]};
        diff    = shifted - {1'b0, dvs_reg};
        fits    = shifted >= {1'b0, dvs_reg};
    end

    // Load on start, then retire one bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[DW-2:0], fits};
            rem_next  = fits ? diff[VW-1:0] : shifted[VW-1:0];
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

FILE: src/smv_dp.sv
// Datapath: accumulators, product and difference stages, shared divider, result registers.
// Depends on smv_pkg and smv_div.

module smv_dp
    import smv_pkg::*;
#(
    parameter int MAX_LEN = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output status_t                stat,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic [MEAN_W-1:0]      mean,
    output logic [SPREAD_W-1:0]    spread,
    output logic                   status
);

    localparam int CNT_W    = $clog2(MAX_LEN + 1);
    localparam int SUM_W    = SAMPLE_BITS + $clog2(MAX_LEN);
    localparam int SQ_W     = 2 * SAMPLE_BITS + $clog2(MAX_LEN);
    localparam int SQ_LO_W  = SQ_W / 2;
    localparam int SQ_HI_W  = SQ_W - SQ_LO_W;
    localparam int PLO_W    = CNT_W + SQ_LO_W;
    localparam int PHI_W    = CNT_W + SQ_HI_W;
    localparam int NA_W     = CNT_W + SQ_W;
    localparam int NB_W     = 2 * SUM_W;
    localparam int NN_W     = 2 * CNT_W;
    localparam int SS_W     = 2 * SAMPLE_BITS;

    logic [CNT_W-1:0]    cnt_reg,   cnt_next;
    logic [SUM_W-1:0]    sum_reg,   sum_next;
    logic [SQ_W-1:0]     sq_reg,    sq_next;
    logic [SS_W-1:0]     samp_sq;
    logic [PLO_W-1:0]    plo_reg;
    logic [PHI_W-1:0]    phi_reg;
    logic [NB_W-1:0]     sum2_reg;
    logic [NN_W-1:0]     nn_reg;
    logic [NA_W-1:0]     num_a_reg;
    logic [NA_W-1:0]     num_reg;
    logic [NA_W-1:0]     sum2_ext;
    logic [NA_W-1:0]     div_dividend;
    logic [NN_W-1:0]     div_divisor;
    logic                div_busy;
    logic [NA_W-1:0]     div_quo;
    logic [SPREAD_W-1:0] var_q_reg;
    logic [MEAN_W-1:0]   mean_reg;
    logic [SPREAD_W-1:0] spread_reg;
    logic                status_reg;

    // Accumulate one item, or clear once a result is loaded
    always_comb
    begin
        samp_sq  = SS_W'(sample) * SS_W'(sample);
        cnt_next = cnt_reg;
        sum_next = sum_reg;
        sq_next  = sq_reg;
        if (cmd.clear)
        begin
            cnt_next = '0;
            sum_next = '0;
            sq_next  = '0;
        end
        else if (cmd.acc_en)
        begin
            cnt_next = cnt_reg + 1'b1;
            sum_next = sum_reg + SUM_W'(sample);
            sq_next  = sq_reg + SQ_W'(samp_sq);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sum_reg <= '0;
            sq_reg  <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            sum_reg <= sum_next;
            sq_reg  <= sq_next;
        end
    end

    // Flags for the item now at the input
    assign stat.hit_max  = (cnt_reg == CNT_W'(MAX_LEN - 1));
    assign stat.single   = (cnt_reg == '0);
    assign stat.div_busy = div_busy;

    // Products: n*sumsq in two halves, sum^2 and n^2
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            plo_reg  <= PLO_W'(cnt_reg) * PLO_W'(sq_reg[SQ_LO_W-1:0]);
            phi_reg  <= PHI_W'(cnt_reg) * PHI_W'(sq_reg[SQ_W-1:SQ_LO_W]);
            sum2_reg <= NB_W'(sum_reg) * NB_W'(sum_reg);
            nn_reg   <= NN_W'(cnt_reg) * NN_W'(cnt_reg);
        end
    end

    // Join the two halves of n*sumsq
    always_ff @(posedge clk)
    begin
        if (cmd.comb_en)
        begin
            num_a_reg <= {phi_reg, {SQ_LO_W{1'b0}}} + NA_W'(plo_reg);
        end
    end

    // Numerator n*sumsq - sum^2, floored at zero
    assign sum2_ext = NA_W'(sum2_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.sub_en)
        begin
            num_reg <= (num_a_reg >= sum2_ext) ? (num_a_reg - sum2_ext) : '0;
        end
    end

    // Shared divider: variance first, then mean
    assign div_dividend = (cmd.div_sel == DIV_SEL_MEAN) ? NA_W'(sum_reg) : num_reg;
    assign div_divisor  = (cmd.div_sel == DIV_SEL_MEAN) ? NN_W'(cnt_reg) : nn_reg;

    smv_div #(
        .DW(NA_W),
        .VW(NN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // Hold the variance while the mean is divided
    always_ff @(posedge clk)
    begin
        if (cmd.var_cap)
        begin
            var_q_reg <= div_quo[SPREAD_W-1:0];
        end
    end

    // Result registers, loaded only when the output is free
    always_ff @(posedge clk)
    begin
        if (cmd.load_ok)
        begin
            mean_reg   <= div_quo[MEAN_W-1:0];
            spread_reg <= var_q_reg;
            status_reg <= STATUS_OK;
        end
        else if (cmd.load_err)
        begin
            mean_reg   <= '0;
            spread_reg <= '0;
            status_reg <= STATUS_SINGLE;
        end
    end

    assign mean   = mean_reg;
    assign spread = spread_reg;
    assign status = status_reg;

endmodule

FILE: src/smv_ctrl.sv
// Controller: sequences accumulation, products, division and result hand-off.
// Depends on smv_pkg.

module smv_ctrl
    import smv_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  logic    last,
    output logic    out_valid,
    input  logic    out_stall,
    input  status_t stat,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_take;
    logic   out_free;
    logic   loading;

    assign in_take  = in_valid && (state_reg == S_ACCUM);
    assign out_free = !out_valid_reg || !out_stall;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.acc_en = in_take;
        case (state_reg)
            S_ACCUM:
            begin
                if (in_take && (last || stat.hit_max))
                begin
                    state_next = stat.single ? S_ERR : S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_COMB;
            end
            S_COMB:
            begin
                cmd.comb_en = 1'b1;
                state_next  = S_SUB;
            end
            S_SUB:
            begin
                cmd.sub_en = 1'b1;
                state_next = S_DIV_VAR;
            end
            S_DIV_VAR:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SEL_VAR;
                state_next    = S_WAIT_VAR;
            end
            S_WAIT_VAR:
            begin
                if (!stat.div_busy)
                begin
                    cmd.var_cap = 1'b1;
                    state_next  = S_DIV_MEAN;
                end
            end
            S_DIV_MEAN:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SEL_MEAN;
                state_next    = S_WAIT_MEAN;
            end
            S_WAIT_MEAN:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_ok = 1'b1;
                    cmd.clear   = 1'b1;
                    state_next  = S_ACCUM;
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    cmd.load_err = 1'b1;
                    cmd.clear    = 1'b1;
                    state_next   = S_ACCUM;
                end
            end
            default:
            begin
                state_next = S_ACCUM;
            end
        endcase
    end

    // Output valid: set on load, drop when the item is taken
    assign loading = cmd.load_ok || cmd.load_err;

    always_comb
    begin
        if (loading)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ACCUM;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_ACCUM);
    assign out_valid = out_valid_reg;

endmodule

FILE: src/stream_mean_variance.sv
// Stream mean and population variance over vectors of unsigned Q0.16 samples.
// Top level; depends on smv_pkg, smv_ctrl and smv_dp.
//
// Each item carries one sample and a last flag. Samples are accumulated at one
// item per cycle. A vector ends on last, or on its MAX_LEN-th sample. The block
// then stalls its input while it forms n*sumsq - sum^2 and n^2 and runs a
// restoring divider, one quotient bit per cycle, twice: once for the variance
// and once for the mean. The divider is DW bits wide, with DW =
// clog2(MAX_LEN+1) + 32 + clog2(MAX_LEN) (53 at MAX_LEN = 1024). A one-sample
// vector gives status 1 with mean and spread zero. Results leave through an
// output register, so the next vector is taken while a result waits.

module stream_mean_variance
    import smv_pkg::*;
#(
    parameter int MAX_LEN = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   last,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [MEAN_W-1:0]      mean,
    output logic [SPREAD_W-1:0]    spread,
    output logic                   status
);

    cmd_t    cmd;
    status_t stat;

    smv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    smv_dp #(
        .MAX_LEN(MAX_LEN)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .stat   (stat),
        .sample (sample),
        .mean   (mean),
        .spread (spread),
        .status (status)
    );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for stream_mean_variance: directed vectors, then random ones.
// Depends on smv_pkg and stream_mean_variance.

module testbench;
    import smv_pkg::*;

    localparam int VEC_MAX     = 1024;
    localparam int PHASE_ITEMS = 215;
    localparam int DRAIN       = 150;
    localparam int ROWS        = 17;
    localparam logic [63:0] SPREAD_MAX = (64'd1 << SPREAD_W) - 1;

    typedef struct packed {
        logic [MEAN_W-1:0]   mean;
        logic [SPREAD_W-1:0] spread;
        logic                status;
    } moments_t;

    typedef struct {
        logic [SAMPLE_BITS-1:0] smp;
        logic                   lst;
        int                     reps;
        bit                     typed;
        moments_t               want;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last;
    logic                   out_valid;
    logic                   out_stall;
    logic [MEAN_W-1:0]      mean;
    logic [SPREAD_W-1:0]    spread;
    logic                   status;

    // Predictor state: running sums of the vector in progress
    logic [25:0] acc_sum;
    logic [41:0] acc_sq;
    logic [10:0] acc_cnt;

    moments_t  pending_moments[$];
    moments_t  got_m;
    moments_t  want_m;
    stim_row_t plan [0:ROWS-1];
    int        err_count;
    int        idle_pct;
    int        stall_pct;
    int        items_sent;

    stream_mean_variance #(
        .MAX_LEN(VEC_MAX)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sample   (sample),
        .last     (last),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .mean     (mean),
        .spread   (spread),
        .status   (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Fold one accepted sample into the sums; close the vector on last or at full length
    task automatic update_moments(input logic [SAMPLE_BITS-1:0] s, input logic l,
                                  output bit done, output moments_t res);
        logic [63:0] s64;
        logic [63:0] n;
        logic [63:0] num_a;
        logic [63:0] num_b;
        logic [63:0] num;
        logic [63:0] q;
        s64     = {48'd0, s};
        acc_sum = acc_sum + s64[25:0];
        acc_sq  = acc_sq + 42'(s64 * s64);
        acc_cnt = acc_cnt + 11'd1;
        done    = l || (acc_cnt >= VEC_MAX);
        res     = '0;
        if (done)
        begin
            n = {53'd0, acc_cnt};
            if (n <= 1)
            begin
                res.status = STATUS_SINGLE;
            end
            else
            begin
                num_a = n * {22'd0, acc_sq};
                num_b = {38'd0, acc_sum} * {38'd0, acc_sum};
                num   = (num_a >= num_b) ? (num_a - num_b) : 64'd0;
                q     = num / (n * n);
                if (q > SPREAD_MAX)
                    q = SPREAD_MAX;
                res.spread = q[SPREAD_W-1:0];
                q          = {38'd0, acc_sum} / n;
                res.mean   = q[MEAN_W-1:0];
                res.status = STATUS_OK;
            end
            acc_sum = '0;
            acc_sq  = '0;
            acc_cnt = '0;
        end
    endtask

    // Offer one item after a random gap, hold it until taken, then queue the result if it closes a vector
    task automatic send_item(input logic [SAMPLE_BITS-1:0] s, input logic l,
                             input bit typed, input moments_t typed_want);
        bit       done;
        moments_t res;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        last     <= l;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        update_moments(s, l, done, res);
        if (done)
            pending_moments.push_back(typed ? typed_want : res);
    endtask

    // Draw one sample: uniform, extremes, a cluster around base, or constant
    function automatic logic [SAMPLE_BITS-1:0] pick_sample(input int mode,
                                                           input logic [SAMPLE_BITS-1:0] base);
        case (mode)
            0: return SAMPLE_BITS'($urandom);
            1: return $urandom_range(0, 1) ? {SAMPLE_BITS{1'b1}} : '0;
            2: return base + SAMPLE_BITS'($urandom_range(0, 15)) - SAMPLE_BITS'(8);
            default: return base;
        endcase
    endfunction

    task automatic send_vector(input int len);
        int                     mode;
        logic [SAMPLE_BITS-1:0] base;
        mode = $urandom_range(0, 3);
        base = SAMPLE_BITS'($urandom);
        for (int k = 0; k < len; k++)
            send_item(pick_sample(mode, base), k == len - 1, 1'b0, '0);
    endtask

    // Check each accepted result against the oldest expectation; randomize the stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got_m = '{mean, spread, status};
            if (pending_moments.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected result, expected none, actual mean=%h spread=%h status=%b",
                         $time, mean, spread, status);
            end
            else
            begin
                want_m = pending_moments.pop_front();
                if (got_m.mean !== want_m.mean)
                begin
                    err_count++;
                    $display("%0t: mean mismatch, expected %h, actual %h",
                             $time, want_m.mean, got_m.mean);
                end
                if (got_m.spread !== want_m.spread)
                begin
                    err_count++;
                    $display("%0t: spread mismatch, expected %h, actual %h",
                             $time, want_m.spread, got_m.spread);
                end
                if (got_m.status !== want_m.status)
                begin
                    err_count++;
                    $display("%0t: status mismatch, expected %b, actual %b",
                             $time, want_m.status, got_m.status);
                end
            end
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Bound the run
    initial
    begin
        #40_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        sample     = '0;
        last       = 1'b0;
        out_stall  = 1'b0;
        acc_sum    = '0;
        acc_sq     = '0;
        acc_cnt    = '0;
        err_count  = 0;
        idle_pct   = 10;
        stall_pct  = 10;
        items_sent = 0;

        // Directed vectors: single samples, extremes, a split full-length vector
        plan = '{
            '{16'hFFFF, 1'b1, 1,   1'b1, '{16'h0000, 31'h0, STATUS_SINGLE}},
            '{16'h0000, 1'b1, 1,   1'b1, '{16'h0000, 31'h0, STATUS_SINGLE}},
            '{16'h0000, 1'b0, 1,   1'b0, '0},
            '{16'hFFFF, 1'b1, 1,   1'b1, '{16'h7FFF, 31'h3FFF8000, STATUS_OK}},
            '{16'hFFFF, 1'b0, 1,   1'b0, '0},
            '{16'hFFFF, 1'b1, 1,   1'b1, '{16'hFFFF, 31'h0, STATUS_OK}},
            '{16'h0000, 1'b0, 1,   1'b0, '0},
            '{16'h0000, 1'b1, 1,   1'b1, '{16'h0000, 31'h0, STATUS_OK}},
            '{16'h8000, 1'b0, 1,   1'b0, '0},
            '{16'h0001, 1'b0, 1,   1'b0, '0},
            '{16'h7FFE, 1'b1, 1,   1'b0, '0},
            '{16'hAAAA, 1'b0, 3,   1'b0, '0},
            '{16'h5555, 1'b1, 2,   1'b0, '0},
            '{16'hFFFF, 1'b0, 512, 1'b0, '0},
            '{16'h0000, 1'b0, 512, 1'b0, '0},
            '{16'hC3C3, 1'b1, 1,   1'b1, '{16'h0000, 31'h0, STATUS_SINGLE}},
            '{16'h1234, 1'b1, 1,   1'b1, '{16'h0000, 31'h0, STATUS_SINGLE}}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table; last applies to the final repeat of a row
        for (int i = 0; i < ROWS; i++)
            for (int r = 0; r < plan[i].reps; r++)
                send_item(plan[i].smp, (r == plan[i].reps - 1) ? plan[i].lst : 1'b0,
                          plan[i].typed, plan[i].want);

        // Random vectors over four idling phases
        for (int ph = 0; ph < 4; ph++)
        begin
            int start_cnt;
            int r;
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 76; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 76; end
                default: begin idle_pct = 10; stall_pct = 10; end
            endcase
            start_cnt = items_sent;
            while (items_sent - start_cnt < PHASE_ITEMS)
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                    send_vector(1);
                else if (r < 20)
                    send_vector($urandom_range(25, 80));
                else
                    send_vector($urandom_range(2, 24));
            end
        end
        in_valid <= 1'b0;

        // Drain outstanding results, then allow for a late extra one
        while (pending_moments.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
src/smv_pkg.sv
src/smv_div.sv
src/smv_dp.sv
src/smv_ctrl.sv
src/stream_mean_variance.sv
tb/testbench.sv
